// ===== rtl/core/psd_pkg.sv =====
// Shared types, constants and width helpers for the point-to-segment distance test.
`timescale 1ns / 1ps
`default_nettype none
package psd_pkg;

   localparam int FRAC_BITS    = 24;
   localparam int DIST_BITS    = 25;
   localparam int CSR_IDX_BITS = 2;
   localparam int END_RESET    = 25600;

   typedef enum logic [1:0] {
      REGION_START    = 2'd0,
      REGION_END      = 2'd1,
      REGION_INTERIOR = 2'd2
   } region_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_START_X = 2'd0,
      CSR_START_Y = 2'd1,
      CSR_END_X   = 2'd2,
      CSR_END_Y   = 2'd3
   } csr_index_type;

   // dot product width, capped at 64 bits
   function automatic int dot_width(input int cb);
      return (2 * cb + 3 > 64) ? 64 : 2 * cb + 3;
   endfunction

   // squared distance width, capped at 64 bits
   function automatic int rad_width(input int cb);
      return (2 * cb + 2 > 64) ? 64 : 2 * cb + 2;
   endfunction

   function automatic int root_width(input int cb);
      return rad_width(cb) / 2;
   endfunction

   function automatic int pipe_latency(input int cb);
      return 35 + root_width(cb);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/point_segment_distance_hit_test.sv =====
// Top level: segment registers, distance pipeline and result stage.
//
// Usage
//   Segment endpoints are loaded over the csr_ channel (csr_valid/csr_ready,
//   csr_index 0..3 = start_x, start_y, end_x, end_y); csr_ready is always high.
//   Write them only while no query is in flight.
//   A query beat (req_point_x, req_point_y, req_tolerance) is taken on any
//   clock edge with start high; busy is always low, so one query per cycle.
//   Each query yields one result beat: rsp_valid high for one cycle with
//   rsp_distance, rsp_hit and rsp_region, in query order.
//   Pipeline stages: 4 dot-product stages, 24 divider stages (one quotient
//   bit each), 6 projection/square stages, one stage per root bit in the
//   square root, and the output register.
//   Throughput: one query per clock.
//   Reset (synchronous) empties the pipeline and loads the default segment
//   (0,0)-(100.0,100.0). The receiver cannot stall; rsp_valid is a strobe.
`timescale 1ns / 1ps
`default_nettype none
module point_segment_distance_hit_test #(
   parameter int COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [COORD_BITS-1:0]          req_point_x,
   input  logic signed [COORD_BITS-1:0]          req_point_y,
   input  logic        [COORD_BITS-1:0]          req_tolerance,
   output logic                                  rsp_valid,
   output logic [psd_pkg::DIST_BITS-1:0]         rsp_distance,
   output logic                                  rsp_hit,
   output logic [1:0]                            rsp_region,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [psd_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [COORD_BITS-1:0]                 csr_data
);
   import psd_pkg::*;

   localparam int CB      = COORD_BITS;
   localparam int DW      = dot_width(COORD_BITS);
   localparam int NW      = rad_width(COORD_BITS);
   localparam int SW      = root_width(COORD_BITS);
   localparam int DSIDE_W = 3 * CB + 2 * (CB + 1) + 2;
   localparam int SSIDE_W = CB + 2;
   localparam int CMPW    = (SW > CB) ? SW : CB;

   logic signed [CB-1:0]  start_x_ff, start_y_ff, end_x_ff, end_y_ff;

   logic                  dot_valid;
   logic [DW-1:0]         dot_c1, dot_c2;
   region_type            dot_region;
   logic signed [CB-1:0]  dot_px, dot_py;
   logic [CB-1:0]         dot_tol;
   logic signed [CB:0]    dot_vx, dot_vy;

   logic                  div_valid;
   logic [FRAC_BITS-1:0]  div_quo;
   logic [DSIDE_W-1:0]    div_side_in, div_side;

   logic                  proj_valid;
   logic [NW-1:0]         proj_rad;
   logic [CB-1:0]         proj_tol;
   region_type            proj_region;

   logic                  sq_valid;
   logic [SW-1:0]         sq_root;
   logic [SSIDE_W-1:0]    sq_side;

   logic                  rsp_valid_ff, rsp_hit_ff;
   logic [DIST_BITS-1:0]  rsp_distance_ff;
   logic [1:0]            rsp_region_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= CB'(END_RESET);
         end_y_ff   <= CB'(END_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_X: start_x_ff <= csr_data;
            CSR_START_Y: start_y_ff <= csr_data;
            CSR_END_X:   end_x_ff   <= csr_data;
            CSR_END_Y:   end_y_ff   <= csr_data;
            default:     start_x_ff <= start_x_ff;
         endcase
      end
   end

   psd_dot #(
      .COORD_BITS (COORD_BITS),
      .DW         (DW)
   ) u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .tolerance (req_tolerance),
      .start_x   (start_x_ff),
      .start_y   (start_y_ff),
      .end_x     (end_x_ff),
      .end_y     (end_y_ff),
      .out_valid (dot_valid),
      .c1        (dot_c1),
      .c2        (dot_c2),
      .region    (dot_region),
      .px        (dot_px),
      .py        (dot_py),
      .tol       (dot_tol),
      .vx        (dot_vx),
      .vy        (dot_vy)
   );

   assign div_side_in = {dot_px, dot_py, dot_tol, dot_vx, dot_vy, dot_region};

   psd_div #(
      .DW     (DW),
      .SIDE_W (DSIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dot_valid),
      .num       (dot_c1),
      .den       (dot_c2),
      .in_side   (div_side_in),
      .out_valid (div_valid),
      .quo       (div_quo),
      .out_side  (div_side)
   );

   psd_proj #(
      .COORD_BITS (COORD_BITS),
      .NW         (NW)
   ) u_proj (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .quo        (div_quo),
      .px         (div_side[DSIDE_W-1 -: CB]),
      .py         (div_side[DSIDE_W-CB-1 -: CB]),
      .tol        (div_side[DSIDE_W-2*CB-1 -: CB]),
      .vx         (div_side[2*CB+3 -: CB+1]),
      .vy         (div_side[CB+2 -: CB+1]),
      .region     (region_type'(div_side[1:0])),
      .start_x    (start_x_ff),
      .start_y    (start_y_ff),
      .end_x      (end_x_ff),
      .end_y      (end_y_ff),
      .out_valid  (proj_valid),
      .rad        (proj_rad),
      .out_tol    (proj_tol),
      .out_region (proj_region)
   );

   psd_sqrt #(
      .NW     (NW),
      .SIDE_W (SSIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (proj_valid),
      .rad       (proj_rad),
      .in_side   ({proj_tol, proj_region}),
      .out_valid (sq_valid),
      .root      (sq_root),
      .out_side  (sq_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_distance_ff <= DIST_BITS'(sq_root);
      rsp_hit_ff      <= CMPW'(sq_root) <= CMPW'(sq_side[SSIDE_W-1 -: CB]);
      rsp_region_ff   <= sq_side[1:0];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_region   = rsp_region_ff;

endmodule
`default_nettype wire

// ===== rtl/core/psd_dot.sv =====
// Front stages: segment and point vectors, dot products, closest-feature decision.
`timescale 1ns / 1ps
`default_nettype none
module psd_dot #(
   parameter int COORD_BITS = 24,
   parameter int DW         = 51
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] point_x,
   input  logic signed [COORD_BITS-1:0] point_y,
   input  logic        [COORD_BITS-1:0] tolerance,
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic                         out_valid,
   output logic        [DW-1:0]         c1,
   output logic        [DW-1:0]         c2,
   output psd_pkg::region_type          region,
   output logic signed [COORD_BITS-1:0] px,
   output logic signed [COORD_BITS-1:0] py,
   output logic        [COORD_BITS-1:0] tol,
   output logic signed [COORD_BITS:0]   vx,
   output logic signed [COORD_BITS:0]   vy
);
   import psd_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int VW = COORD_BITS + 1;
   localparam int PW = 2 * VW;

   logic                 vld_s1_ff, vld_s2_ff, vld_s3_ff, vld_s4_ff;
   logic signed [VW-1:0] vx_s1_ff, vy_s1_ff, wx_s1_ff, wy_s1_ff;
   logic signed [VW-1:0] vx_s2_ff, vy_s2_ff, vx_s3_ff, vy_s3_ff, vx_s4_ff, vy_s4_ff;
   logic signed [CB-1:0] px_s1_ff, py_s1_ff, px_s2_ff, py_s2_ff;
   logic signed [CB-1:0] px_s3_ff, py_s3_ff, px_s4_ff, py_s4_ff;
   logic        [CB-1:0] tol_s1_ff, tol_s2_ff, tol_s3_ff, tol_s4_ff;
   logic signed [PW-1:0] pxx_s2_ff, pyy_s2_ff, vxx_s2_ff, vyy_s2_ff;
   logic        [DW-1:0] c1_s3_ff, c2_s3_ff, c1_s4_ff, c2_s4_ff;
   region_type           region_in, region_s4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s1_ff <= 1'b0;
         vld_s2_ff <= 1'b0;
         vld_s3_ff <= 1'b0;
         vld_s4_ff <= 1'b0;
      end else begin
         vld_s1_ff <= in_valid;
         vld_s2_ff <= vld_s1_ff;
         vld_s3_ff <= vld_s2_ff;
         vld_s4_ff <= vld_s3_ff;
      end
   end

   always_ff @(posedge clock) begin
      vx_s1_ff  <= {end_x[CB-1], end_x} - {start_x[CB-1], start_x};
      vy_s1_ff  <= {end_y[CB-1], end_y} - {start_y[CB-1], start_y};
      wx_s1_ff  <= {point_x[CB-1], point_x} - {start_x[CB-1], start_x};
      wy_s1_ff  <= {point_y[CB-1], point_y} - {start_y[CB-1], start_y};
      px_s1_ff  <= point_x;
      py_s1_ff  <= point_y;
      tol_s1_ff <= tolerance;

      pxx_s2_ff <= vx_s1_ff * wx_s1_ff;
      pyy_s2_ff <= vy_s1_ff * wy_s1_ff;
      vxx_s2_ff <= vx_s1_ff * vx_s1_ff;
      vyy_s2_ff <= vy_s1_ff * vy_s1_ff;
      vx_s2_ff  <= vx_s1_ff;
      vy_s2_ff  <= vy_s1_ff;
      px_s2_ff  <= px_s1_ff;
      py_s2_ff  <= py_s1_ff;
      tol_s2_ff <= tol_s1_ff;

      c1_s3_ff  <= DW'(pxx_s2_ff) + DW'(pyy_s2_ff);
      c2_s3_ff  <= DW'(vxx_s2_ff) + DW'(vyy_s2_ff);
      vx_s3_ff  <= vx_s2_ff;
      vy_s3_ff  <= vy_s2_ff;
      px_s3_ff  <= px_s2_ff;
      py_s3_ff  <= py_s2_ff;
      tol_s3_ff <= tol_s2_ff;

      c1_s4_ff     <= c1_s3_ff;
      c2_s4_ff     <= c2_s3_ff;
      region_s4_ff <= region_in;
      vx_s4_ff     <= vx_s3_ff;
      vy_s4_ff     <= vy_s3_ff;
      px_s4_ff     <= px_s3_ff;
      py_s4_ff     <= py_s3_ff;
      tol_s4_ff    <= tol_s3_ff;
   end

   always_comb begin
      priority if ((c1_s3_ff == '0) || c1_s3_ff[DW-1]) begin
         region_in = REGION_START;
      end else if (c2_s3_ff <= c1_s3_ff) begin
         region_in = REGION_END;
      end else begin
         region_in = REGION_INTERIOR;
      end
   end

   assign out_valid = vld_s4_ff;
   assign c1        = c1_s4_ff;
   assign c2        = c2_s4_ff;
   assign region    = region_s4_ff;
   assign px        = px_s4_ff;
   assign py        = py_s4_ff;
   assign tol       = tol_s4_ff;
   assign vx        = vx_s4_ff;
   assign vy        = vy_s4_ff;

endmodule
`default_nettype wire

// ===== rtl/core/psd_div.sv =====
// Pipelined restoring divider: one quotient bit of c1/c2 per stage.
`timescale 1ns / 1ps
`default_nettype none
module psd_div #(
   parameter int DW     = 51,
   parameter int SIDE_W = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic [DW-1:0]                      num,
   input  logic [DW-1:0]                      den,
   input  logic [SIDE_W-1:0]                  in_side,
   output logic                               out_valid,
   output logic [psd_pkg::FRAC_BITS-1:0]      quo,
   output logic [SIDE_W-1:0]                  out_side
);
   import psd_pkg::*;

   localparam int STEPS = FRAC_BITS;

   logic                 vld_ff  [STEPS];
   logic [DW-1:0]        rem_ff  [STEPS];
   logic [DW-1:0]        den_ff  [STEPS];
   logic [STEPS-1:0]     quo_ff  [STEPS];
   logic [SIDE_W-1:0]    side_ff [STEPS];

   logic                 vld_src  [STEPS];
   logic [DW-1:0]        rem_src  [STEPS];
   logic [DW-1:0]        den_src  [STEPS];
   logic [STEPS-1:0]     quo_src  [STEPS];
   logic [SIDE_W-1:0]    side_src [STEPS];
   logic [DW-1:0]        rem_sh   [STEPS];
   logic                 take     [STEPS];
   logic [DW-1:0]        rem_in   [STEPS];
   logic [STEPS-1:0]     quo_in   [STEPS];

   always_comb begin
      vld_src[0]  = in_valid;
      rem_src[0]  = num;
      den_src[0]  = den;
      quo_src[0]  = '0;
      side_src[0] = in_side;
      for (int k = 1; k < STEPS; k++) begin
         vld_src[k]  = vld_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         den_src[k]  = den_ff[k-1];
         quo_src[k]  = quo_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
      for (int k = 0; k < STEPS; k++) begin
         rem_sh[k] = {rem_src[k][DW-2:0], 1'b0};
         take[k]   = rem_sh[k] >= den_src[k];
         rem_in[k] = take[k] ? rem_sh[k] - den_src[k] : rem_sh[k];
         quo_in[k] = {quo_src[k][STEPS-2:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STEPS; k++) vld_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < STEPS; k++) vld_ff[k] <= vld_src[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STEPS; k++) begin
         rem_ff[k]  <= rem_in[k];
         den_ff[k]  <= den_src[k];
         quo_ff[k]  <= quo_in[k];
         side_ff[k] <= side_src[k];
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign quo       = quo_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/core/psd_proj.sv =====
// Projection offset, reference point selection and squared distance.
`timescale 1ns / 1ps
`default_nettype none
module psd_proj #(
   parameter int COORD_BITS = 24,
   parameter int NW         = 50
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [psd_pkg::FRAC_BITS-1:0]     quo,
   input  logic signed [COORD_BITS-1:0]      px,
   input  logic signed [COORD_BITS-1:0]      py,
   input  logic        [COORD_BITS-1:0]      tol,
   input  logic signed [COORD_BITS:0]        vx,
   input  logic signed [COORD_BITS:0]        vy,
   input  psd_pkg::region_type               region,
   input  logic signed [COORD_BITS-1:0]      start_x,
   input  logic signed [COORD_BITS-1:0]      start_y,
   input  logic signed [COORD_BITS-1:0]      end_x,
   input  logic signed [COORD_BITS-1:0]      end_y,
   output logic                              out_valid,
   output logic [NW-1:0]                     rad,
   output logic [COORD_BITS-1:0]             out_tol,
   output psd_pkg::region_type               out_region
);
   import psd_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int VW = COORD_BITS + 1;
   localparam int MW = FRAC_BITS + VW;
   localparam int OW = COORD_BITS + 2;

   logic                 vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff, vld_e_ff, vld_f_ff;
   logic [VW-1:0]        magx, magy;
   logic [MW-1:0]        mx_a_ff, my_a_ff;
   logic                 negx_a_ff, negy_a_ff;
   logic [MW:0]          sumx, sumy;
   logic [OW-1:0]        qx, qy;
   logic signed [OW-1:0] offx_b_ff, offy_b_ff;
   logic signed [OW-1:0] refx_in, refy_in, refx_c_ff, refy_c_ff;
   logic signed [OW-1:0] sx_ext, sy_ext;
   logic signed [OW:0]   dx, dy;
   logic [OW:0]          adx, ady;
   logic [VW-1:0]        dx_d_ff, dy_d_ff;
   logic [2*VW-1:0]      sqx_e_ff, sqy_e_ff;
   logic [NW-1:0]        rad_f_ff;
   logic signed [CB-1:0] px_a_ff, py_a_ff, px_b_ff, py_b_ff, px_c_ff, py_c_ff;
   logic [CB-1:0]        tol_a_ff, tol_b_ff, tol_c_ff, tol_d_ff, tol_e_ff, tol_f_ff;
   region_type           reg_a_ff, reg_b_ff, reg_c_ff, reg_d_ff, reg_e_ff, reg_f_ff;

   assign magx   = vx[CB] ? VW'(-vx) : VW'(vx);
   assign magy   = vy[CB] ? VW'(-vy) : VW'(vy);
   assign sumx   = {1'b0, mx_a_ff} + (MW + 1)'(1 << (FRAC_BITS - 1));
   assign sumy   = {1'b0, my_a_ff} + (MW + 1)'(1 << (FRAC_BITS - 1));
   assign qx     = sumx[MW:FRAC_BITS];
   assign qy     = sumy[MW:FRAC_BITS];
   assign sx_ext = {{2{start_x[CB-1]}}, start_x};
   assign sy_ext = {{2{start_y[CB-1]}}, start_y};

   always_comb begin
      unique case (reg_b_ff)
         REGION_START: begin
            refx_in = sx_ext;
            refy_in = sy_ext;
         end
         REGION_END: begin
            refx_in = {{2{end_x[CB-1]}}, end_x};
            refy_in = {{2{end_y[CB-1]}}, end_y};
         end
         REGION_INTERIOR: begin
            refx_in = sx_ext + offx_b_ff;
            refy_in = sy_ext + offy_b_ff;
         end
         default: begin
            refx_in = sx_ext;
            refy_in = sy_ext;
         end
      endcase
   end

   assign dx  = {{3{px_c_ff[CB-1]}}, px_c_ff} - {refx_c_ff[OW-1], refx_c_ff};
   assign dy  = {{3{py_c_ff[CB-1]}}, py_c_ff} - {refy_c_ff[OW-1], refy_c_ff};
   assign adx = dx[OW] ? (OW + 1)'(-dx) : (OW + 1)'(dx);
   assign ady = dy[OW] ? (OW + 1)'(-dy) : (OW + 1)'(dy);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
         vld_e_ff <= 1'b0;
         vld_f_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
         vld_d_ff <= vld_c_ff;
         vld_e_ff <= vld_d_ff;
         vld_f_ff <= vld_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      mx_a_ff   <= quo * magx;
      my_a_ff   <= quo * magy;
      negx_a_ff <= vx[CB];
      negy_a_ff <= vy[CB];
      px_a_ff   <= px;
      py_a_ff   <= py;
      tol_a_ff  <= tol;
      reg_a_ff  <= region;

      offx_b_ff <= negx_a_ff ? -qx : qx;
      offy_b_ff <= negy_a_ff ? -qy : qy;
      px_b_ff   <= px_a_ff;
      py_b_ff   <= py_a_ff;
      tol_b_ff  <= tol_a_ff;
      reg_b_ff  <= reg_a_ff;

      refx_c_ff <= refx_in;
      refy_c_ff <= refy_in;
      px_c_ff   <= px_b_ff;
      py_c_ff   <= py_b_ff;
      tol_c_ff  <= tol_b_ff;
      reg_c_ff  <= reg_b_ff;

      dx_d_ff   <= adx[VW-1:0];
      dy_d_ff   <= ady[VW-1:0];
      tol_d_ff  <= tol_c_ff;
      reg_d_ff  <= reg_c_ff;

      sqx_e_ff  <= dx_d_ff * dx_d_ff;
      sqy_e_ff  <= dy_d_ff * dy_d_ff;
      tol_e_ff  <= tol_d_ff;
      reg_e_ff  <= reg_d_ff;

      rad_f_ff  <= NW'(sqx_e_ff) + NW'(sqy_e_ff);
      tol_f_ff  <= tol_e_ff;
      reg_f_ff  <= reg_e_ff;
   end

   assign out_valid  = vld_f_ff;
   assign rad        = rad_f_ff;
   assign out_tol    = tol_f_ff;
   assign out_region = reg_f_ff;

endmodule
`default_nettype wire

// ===== rtl/core/psd_sqrt.sv =====
// Pipelined floor square root: one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module psd_sqrt #(
   parameter int NW     = 50,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [NW-1:0]       rad,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [NW/2-1:0]     root,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int SW = NW / 2;

   logic              vld_ff  [SW];
   logic [SW:0]       rem_ff  [SW];
   logic [SW-1:0]     root_ff [SW];
   logic [NW-1:0]     rad_ff  [SW];
   logic [SIDE_W-1:0] side_ff [SW];

   logic              vld_src  [SW];
   logic [SW:0]       rem_src  [SW];
   logic [SW-1:0]     root_src [SW];
   logic [NW-1:0]     rad_src  [SW];
   logic [SIDE_W-1:0] side_src [SW];
   logic [SW+1:0]     trial    [SW];
   logic [SW+1:0]     test     [SW];
   logic [SW+1:0]     diff     [SW];
   logic              take     [SW];

   always_comb begin
      vld_src[0]  = in_valid;
      rem_src[0]  = '0;
      root_src[0] = '0;
      rad_src[0]  = rad;
      side_src[0] = in_side;
      for (int k = 1; k < SW; k++) begin
         vld_src[k]  = vld_ff[k-1];
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         rad_src[k]  = rad_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
      for (int k = 0; k < SW; k++) begin
         trial[k] = {rem_src[k][SW-1:0], rad_src[k][NW-1 -: 2]};
         test[k]  = {root_src[k], 2'b01};
         take[k]  = trial[k] >= test[k];
         diff[k]  = trial[k] - test[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SW; k++) vld_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < SW; k++) vld_ff[k] <= vld_src[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SW; k++) begin
         rem_ff[k]  <= take[k] ? diff[k][SW:0] : trial[k][SW:0];
         root_ff[k] <= {root_src[k][SW-2:0], take[k]};
         rad_ff[k]  <= {rad_src[k][NW-3:0], 2'b00};
         side_ff[k] <= side_src[k];
      end
   end

   assign out_valid = vld_ff[SW-1];
   assign root      = root_ff[SW-1];
   assign out_side  = side_ff[SW-1];

endmodule
`default_nettype wire

// ===== rtl/core/psd_checker.sv =====
// Port-level checks for the distance pipeline, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module psd_checker #(
   parameter int COORD_BITS = 24
) (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_region
);
   import psd_pkg::*;

   localparam int LAT = pipe_latency(COORD_BITS);

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted beat without result at fixed latency");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result beat without matching request");

   a_region : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_region == REGION_START || rsp_region == REGION_END ||
                     rsp_region == REGION_INTERIOR))
      else $error("illegal region code");

   a_reset_flush : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

endmodule

bind point_segment_distance_hit_test psd_checker #(.COORD_BITS(COORD_BITS)) u_psd_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_region (rsp_region)
);
`default_nettype wire

// ===== sim/point_segment_distance_hit_test_checker.sv =====
// Checker: watches segment register writes, queries and results, predicts distance, hit and region and compares.
`timescale 1ns / 1ps
module point_segment_distance_hit_test_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic signed [23:0]                req_point_x,
   input  logic signed [23:0]                req_point_y,
   input  logic [23:0]                       req_tolerance,
   input  logic                              rsp_valid,
   input  logic [psd_pkg::DIST_BITS-1:0]     rsp_distance,
   input  logic                              rsp_hit,
   input  logic [1:0]                        rsp_region,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [psd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [23:0]                       csr_data,
   output int                                fail_count,
   output int                                pending,
   output int                                result_count
);
   import psd_pkg::*;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic                 hit;
      region_type           region;
   } answer_type;

   answer_type answers[$];
   logic signed [23:0] seg_sx, seg_sy, seg_ex, seg_ey;

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned dist_between(longint px, longint py, longint qx,
                                                    longint qy);
      longint dx, dy;
      dx = px - qx;
      dy = py - qy;
      return floor_root(dx * dx + dy * dy);
   endfunction

   function automatic longint along(longint unsigned b, longint v);
      longint unsigned m, q;
      m = b * (v < 0 ? -v : v);
      q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic answer_type nearest_feature(longint px, longint py,
                                                  longint unsigned tol);
      longint sx, sy, vx, vy, wx, wy, c1, c2;
      longint unsigned b, r, d;
      answer_type a;
      sx = seg_sx;
      sy = seg_sy;
      vx = longint'(seg_ex) - sx;
      vy = longint'(seg_ey) - sy;
      wx = px - sx;
      wy = py - sy;
      c1 = vx * wx + vy * wy;
      c2 = vx * vx + vy * vy;
      if (c1 <= 0) begin
         a.region = REGION_START;
         d = dist_between(px, py, sx, sy);
      end else if (c2 <= c1) begin
         a.region = REGION_END;
         d = dist_between(px, py, seg_ex, seg_ey);
      end else begin
         r = c1;
         b = 0;
         for (int i = 0; i < FRAC_BITS; i++) begin
            r <<= 1;
            b <<= 1;
            if (r >= c2) begin
               r -= c2;
               b |= 1;
            end
         end
         a.region = REGION_INTERIOR;
         d = dist_between(px, py, sx + along(b, vx), sy + along(b, vy));
      end
      a.distance = d[DIST_BITS-1:0];
      a.hit = d <= tol;
      return a;
   endfunction

   assign pending = answers.size();

   always @(posedge clock) begin
      answer_type want;
      int errs;
      errs = 0;
      if (reset) begin
         seg_sx <= '0;
         seg_sy <= '0;
         seg_ex <= 24'(END_RESET);
         seg_ey <= 24'(END_RESET);
         fail_count <= 0;
         result_count <= 0;
         answers.delete();
      end else begin
         if (start && !busy)
            answers.push_back(nearest_feature(req_point_x, req_point_y, req_tolerance));
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (answers.size() == 0) begin
               $error("result beat with nothing expected");
               errs++;
            end else begin
               want = answers.pop_front();
               if (rsp_distance !== want.distance) begin
                  $error("distance: expected %0d, got %0d", want.distance, rsp_distance);
                  errs++;
               end
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  errs++;
               end
               if (rsp_region !== want.region) begin
                  $error("region: expected %0d, got %0d", want.region, rsp_region);
                  errs++;
               end
            end
            fail_count <= fail_count + errs;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_START_X: seg_sx <= csr_data;
               CSR_START_Y: seg_sy <= csr_data;
               CSR_END_X:   seg_ex <= csr_data;
               CSR_END_Y:   seg_ey <= csr_data;
            endcase
         end
      end
   end
endmodule

// ===== sim/point_segment_distance_hit_test_test.sv =====
// Testbench top: clock, reset, segment setup phases, query stimulus and verdict.
`timescale 1ns / 1ps
module point_segment_distance_hit_test_test;
   import psd_pkg::*;

   localparam int LATENCY = pipe_latency(24);

   logic clock = 0, reset = 1, start = 0, busy, csr_valid = 0, csr_ready;
   logic signed [23:0] req_point_x = 0, req_point_y = 0;
   logic [23:0] req_tolerance = 0, csr_data = 0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_START_X;
   logic rsp_valid, rsp_hit;
   logic [DIST_BITS-1:0] rsp_distance;
   logic [1:0] rsp_region;
   int fail_count, pending, result_count, query_count, quiet_from, quiet_to;

   always #6 clock = ~clock;

   point_segment_distance_hit_test DUT (.*);
   point_segment_distance_hit_test_checker watcher (.*);

   task automatic write_reg(csr_index_type idx, logic [23:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_segment(logic [23:0] sx, sy, ex, ey);
      write_reg(CSR_START_X, sx);
      write_reg(CSR_START_Y, sy);
      write_reg(CSR_END_X, ex);
      write_reg(CSR_END_Y, ey);
   endtask

   task automatic query(logic [23:0] px, py, tol);
      while (!(query_count >= quiet_from && query_count < quiet_to) &&
             $urandom_range(99) < 11) begin
         start <= 0;
         @(negedge clock);
      end
      req_point_x <= px;
      req_point_y <= py;
      req_tolerance <= tol;
      start <= 1;
      do @(posedge clock); while (busy);
      query_count++;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
   endtask

   // near the segment most of the time, anywhere otherwise
   function automatic logic [23:0] coord_pick(logic [23:0] base);
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return base + 24'($urandom_range(4095)) - 24'd2048;
         default: return base + 24'($urandom_range(65535)) - 24'd32768;
      endcase
   endfunction

   task automatic random_queries(int count, logic [23:0] sx, sy, ex, ey);
      logic [23:0] t;
      for (int i = 0; i < count; i++) begin
         t = $urandom_range(99) < 70 ? 24'($urandom_range(40000)) : 24'($urandom);
         if ($urandom_range(1)) query(coord_pick(sx), coord_pick(sy), t);
         else query(coord_pick(ex), coord_pick(ey), t);
      end
   endtask

   initial begin
      #20_000_000;
      $display("** point_segment_distance_hit_test: FAILED **");
      $finish;
   end

   initial begin
      logic [23:0] s[4];
      quiet_from = 600;
      quiet_to = 850;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // default segment: start, end, interior, on the perpendicular, extremes
      query(24'h000000, 24'h000000, 24'h000000);
      query(24'd25600, 24'd25600, 24'h000000);
      query(24'd12800, 24'd12800, 24'h000000);
      query(24'd256, -24'sd256, 24'd10);
      query(24'd25700, 24'd25800, 24'd100);
      query(24'd100, 24'd20000, 24'hffffff);
      query(24'h800000, 24'h800000, 24'hffffff);
      query(24'h7fffff, 24'h7fffff, 24'h000000);
      query(24'h7fffff, 24'h800000, 24'd500);
      query(24'd3000, 24'd9000, 24'd4525);
      drain();
      // degenerate segment
      set_segment(24'd500, -24'sd700, 24'd500, -24'sd700);
      query(24'd500, -24'sd700, 24'd0);
      query(24'h555555, 24'haaaaaa, 24'haaaaaa);
      drain();
      // extreme endpoints
      set_segment(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
      query(24'h000000, 24'h000000, 24'd0);
      query(24'h7fffff, 24'h800000, 24'hffffff);
      query(24'h800000, 24'h7fffff, 24'd1);
      query(24'h800000, 24'h800000, 24'd0);
      query(24'h7fffff, 24'h7fffff, 24'd0);
      drain();
      set_segment(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff);
      random_queries(150, 24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff);
      drain();
      for (int p = 0; p < 8; p++) begin
         foreach (s[k]) s[k] = p < 5 ? 24'($urandom_range(131071)) - 24'd65536
                                     : 24'($urandom);
         set_segment(s[0], s[1], s[2], s[3]);
         random_queries(160, s[0], s[1], s[2], s[3]);
         drain();
      end
      $display("Covered %0d queries and %0d results over twelve segment settings.",
               query_count, result_count);
      if (fail_count == 0)
         $display("** point_segment_distance_hit_test: PASSED **");
      else
         $display("** point_segment_distance_hit_test: FAILED **");
      $finish;
   end
endmodule

// ===== point_segment_distance_hit_test.f =====
rtl/core/psd_pkg.sv
rtl/core/psd_dot.sv
rtl/core/psd_div.sv
rtl/core/psd_proj.sv
rtl/core/psd_sqrt.sv
rtl/core/point_segment_distance_hit_test.sv
rtl/core/psd_checker.sv
sim/point_segment_distance_hit_test_checker.sv
sim/point_segment_distance_hit_test_test.sv
